>>> rtl/core/mvwd_pkg.sv
// shared types and constants of the mesh vertex weld core
`timescale 1ns / 1ps
package mvwd_pkg;
	localparam int MaxVertices = 4096;
	localparam int MaxTriangles = 8192;
	localparam int VIdxW = $clog2(MaxVertices);
	localparam int VCntW = $clog2(MaxVertices + 1);
	localparam int TIdxW = $clog2(MaxTriangles);
	localparam int TCntW = $clog2(MaxTriangles + 1);
	localparam int CoordW = 24;
	localparam int DistW = 52;

	localparam logic [1:0] OpVertex = 2'd0;
	localparam logic [1:0] OpTriangle = 2'd1;
	localparam logic [1:0] OpClear = 2'd2;
	localparam logic [1:0] OpReserved = 2'd3;

	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StVertFull = 2'd1;
	localparam logic [1:0] StTriFull = 2'd2;
	localparam logic [1:0] StBadIndex = 2'd3;

	localparam logic CfgWeldEnable = 1'b0;
	localparam logic CfgThreshold = 1'b1;

	typedef struct packed {
		logic [1:0] opcode;
		logic signed [CoordW-1:0] pos_x;
		logic signed [CoordW-1:0] pos_y;
		logic signed [CoordW-1:0] pos_z;
		logic [VIdxW-1:0] corner_a;
		logic [VIdxW-1:0] corner_b;
		logic [VIdxW-1:0] corner_c;
	} item_t;

	typedef struct packed {
		logic [1:0] item_kind;
		logic [VIdxW-1:0] reduced_index;
		logic is_new;
		logic [VIdxW-1:0] out_a;
		logic [VIdxW-1:0] out_b;
		logic [VIdxW-1:0] out_c;
		logic [1:0] status;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;        // capture input item
		logic clear;       // reset counts
		logic vscan_start; // zero vertex scan pointer
		logic vscan_step;  // issue one vertex compare
		logic rmap_rd;     // read remap entry for corner sel
		logic [1:0] rmap_sel;
		logic tscan_start;
		logic tscan_step;
		logic vcommit;     // write vertex result
		logic tcommit;     // write triangle result
		logic [1:0] tcase; // status class for triangle
		logic res_load;
		logic vfull_res;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic vert_full;
		logic bad_corner;
		logic weld_en;
		logic vscan_done;
		logic tscan_done;
		logic tri_full;
		logic pipe_idle;
	} dp_stat_t;
endpackage

>>> rtl/core/mvwd_datapath.sv
// datapath: vertex and triangle stores, distance compare, remap and result register
`timescale 1ns / 1ps
module mvwd_datapath import mvwd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  item_t in_item,
	input  logic cfg_we,
	input  logic cfg_idx,
	input  logic [DistW-1:0] cfg_data,
	input  dp_cmd_t cmd,
	output dp_stat_t stat,
	output result_t res
);
	logic weld_q;
	logic [DistW-1:0] thr_q;
	item_t it_q;
	logic [VCntW-1:0] orig_cnt_q, uniq_cnt_q;
	logic [TCntW-1:0] tri_cnt_q;

	logic [CoordW-1:0] mem_x [MaxVertices];
	logic [CoordW-1:0] mem_y [MaxVertices];
	logic [CoordW-1:0] mem_z [MaxVertices];
	logic [VIdxW-1:0] mem_r [MaxVertices];
	logic [3*VIdxW-1:0] mem_t [MaxTriangles];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weld_q <= 1'b1;
			thr_q <= DistW'(1);
		end else if (cfg_we) begin
			if (cfg_idx == CfgWeldEnable) weld_q <= cfg_data[0];
			else thr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) if (cmd.load) it_q <= in_item;

	// vertex scan: read s1, diff s2, square s3, sum s4, compare s5
	logic [VCntW-1:0] vptr_q;
	logic v_s1, v_s2, v_s3, v_s4;
	logic [VIdxW-1:0] i_s1, i_s2, i_s3, i_s4;
	logic [CoordW-1:0] rx_s1, ry_s1, rz_s1;
	logic [CoordW:0] dx_s2, dy_s2, dz_s2;
	logic [2*CoordW-1:0] qx_s3, qy_s3, qz_s3;
	logic [DistW-1:0] d_s4;
	logic found_q;
	logic [VIdxW-1:0] fidx_q;

	always_ff @(posedge clk) begin
		rx_s1 <= mem_x[vptr_q[VIdxW-1:0]];
		ry_s1 <= mem_y[vptr_q[VIdxW-1:0]];
		rz_s1 <= mem_z[vptr_q[VIdxW-1:0]];
		i_s1 <= vptr_q[VIdxW-1:0];
		i_s2 <= i_s1;
		i_s3 <= i_s2;
		i_s4 <= i_s3;
		dx_s2 <= {it_q.pos_x[CoordW-1], it_q.pos_x} - {rx_s1[CoordW-1], rx_s1};
		dy_s2 <= {it_q.pos_y[CoordW-1], it_q.pos_y} - {ry_s1[CoordW-1], ry_s1};
		dz_s2 <= {it_q.pos_z[CoordW-1], it_q.pos_z} - {rz_s1[CoordW-1], rz_s1};
		qx_s3 <= (2*CoordW)'($signed(dx_s2) * $signed(dx_s2));
		qy_s3 <= (2*CoordW)'($signed(dy_s2) * $signed(dy_s2));
		qz_s3 <= (2*CoordW)'($signed(dz_s2) * $signed(dz_s2));
		d_s4 <= DistW'(qx_s3) + DistW'(qy_s3) + DistW'(qz_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vptr_q <= '0;
			{v_s1, v_s2, v_s3, v_s4} <= '0;
			found_q <= 1'b0;
		end else begin
			v_s1 <= cmd.vscan_step;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (cmd.vscan_start) begin
				vptr_q <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.vscan_step) vptr_q <= vptr_q + 1'b1;
				if (v_s4 && d_s4 < thr_q) found_q <= 1'b1;
			end
		end
	end
	always_ff @(posedge clk) if (v_s4 && d_s4 < thr_q) fidx_q <= i_s4;

	// remap reads of the three corners
	logic [VIdxW-1:0] rd_q, ra_q, rb_q, rc_q;
	logic [VIdxW-1:0] rsel;
	logic rv_q;
	logic [1:0] rs_q;
	always_comb begin
		case (cmd.rmap_sel)
			2'd0: rsel = it_q.corner_a;
			2'd1: rsel = it_q.corner_b;
			default: rsel = it_q.corner_c;
		endcase
	end
	always_ff @(posedge clk) begin
		rd_q <= mem_r[rsel];
		rs_q <= cmd.rmap_sel;
		if (rv_q) begin
			case (rs_q)
				2'd0: ra_q <= rd_q;
				2'd1: rb_q <= rd_q;
				default: rc_q <= rd_q;
			endcase
		end
	end
	always_ff @(posedge clk or negedge arst_n)
		if (!arst_n) rv_q <= 1'b0; else rv_q <= cmd.rmap_rd;

	// triangle scan: read s1, compare s2
	logic [TCntW-1:0] tptr_q;
	logic t_s1;
	logic [3*VIdxW-1:0] tr_s1;
	logic dup_q;
	always_ff @(posedge clk) tr_s1 <= mem_t[tptr_q[TIdxW-1:0]];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tptr_q <= '0;
			t_s1 <= 1'b0;
			dup_q <= 1'b0;
		end else begin
			t_s1 <= cmd.tscan_step;
			if (cmd.tscan_start) begin
				tptr_q <= '0;
				dup_q <= 1'b0;
			end else begin
				if (cmd.tscan_step) tptr_q <= tptr_q + 1'b1;
				if (t_s1 && tr_s1 == {ra_q, rb_q, rc_q}) dup_q <= 1'b1;
			end
		end
	end

	// commits and counts
	logic [VIdxW-1:0] uslot;
	assign uslot = (uniq_cnt_q >= VCntW'(MaxVertices)) ? VIdxW'(MaxVertices - 1)
		: uniq_cnt_q[VIdxW-1:0];
	logic [VIdxW-1:0] vidx;
	assign vidx = found_q ? fidx_q : uslot;

	always_ff @(posedge clk) begin
		if (cmd.vcommit) begin
			if (!found_q) begin
				mem_x[uslot] <= it_q.pos_x;
				mem_y[uslot] <= it_q.pos_y;
				mem_z[uslot] <= it_q.pos_z;
			end
			mem_r[orig_cnt_q[VIdxW-1:0]] <= vidx;
		end
		if (cmd.tcommit && cmd.tcase == StOk && !dup_q && !stat.tri_full)
			mem_t[tri_cnt_q[TIdxW-1:0]] <= {ra_q, rb_q, rc_q};
	end

	// index and table state as seen before the commit
	logic [VIdxW-1:0] vres_q;
	logic tfull_q;
	always_ff @(posedge clk) begin
		if (cmd.vcommit) vres_q <= vidx;
		if (cmd.tcommit) tfull_q <= stat.tri_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orig_cnt_q <= '0;
			uniq_cnt_q <= '0;
			tri_cnt_q <= '0;
		end else if (cmd.clear) begin
			orig_cnt_q <= '0;
			uniq_cnt_q <= '0;
			tri_cnt_q <= '0;
		end else begin
			if (cmd.vcommit) begin
				orig_cnt_q <= orig_cnt_q + 1'b1;
				if (!found_q && uniq_cnt_q < VCntW'(MaxVertices))
					uniq_cnt_q <= uniq_cnt_q + 1'b1;
			end
			if (cmd.tcommit && cmd.tcase == StOk && !dup_q && !stat.tri_full)
				tri_cnt_q <= tri_cnt_q + 1'b1;
		end
	end

	// result register
	result_t res_d;
	always_comb begin
		res_d = '0;
		res_d.item_kind = it_q.opcode;
		if (it_q.opcode == OpVertex) begin
			if (cmd.vfull_res) res_d.status = StVertFull;
			else begin
				res_d.reduced_index = vres_q;
				res_d.is_new = !found_q;
			end
		end else if (it_q.opcode == OpTriangle) begin
			case (cmd.tcase)
				StBadIndex: res_d.status = StBadIndex;
				StVertFull: begin
					// pass-through mode
					res_d.out_a = it_q.corner_a;
					res_d.out_b = it_q.corner_b;
					res_d.out_c = it_q.corner_c;
					res_d.is_new = 1'b1;
				end
				default: begin
					res_d.out_a = ra_q;
					res_d.out_b = rb_q;
					res_d.out_c = rc_q;
					if (!dup_q) begin
						if (tfull_q) res_d.status = StTriFull;
						else res_d.is_new = 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) if (cmd.res_load) res <= res_d;

	assign stat.vert_full = orig_cnt_q >= VCntW'(MaxVertices);
	assign stat.bad_corner = (VCntW'(it_q.corner_a) >= orig_cnt_q)
		|| (VCntW'(it_q.corner_b) >= orig_cnt_q) || (VCntW'(it_q.corner_c) >= orig_cnt_q);
	assign stat.weld_en = weld_q;
	assign stat.vscan_done = (vptr_q >= uniq_cnt_q) || (vptr_q >= VCntW'(MaxVertices));
	assign stat.tscan_done = (tptr_q >= tri_cnt_q) || dup_q;
	assign stat.tri_full = tri_cnt_q >= TCntW'(MaxTriangles);
	assign stat.pipe_idle = !(v_s1 || v_s2 || v_s3 || v_s4 || t_s1 || rv_q);

	a_commit_no_scan: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.vcommit && cmd.vscan_step)) else $error("commit during scan");
	a_commit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.vcommit && !stat.pipe_idle)) else $error("commit before drain");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.vcommit && stat.vert_full)) else $error("vertex overflow");
endmodule

>>> rtl/core/mvwd_ctrl.sv
// controller state machine sequencing vertex scans, triangle lookups and clears
`timescale 1ns / 1ps
module mvwd_ctrl import mvwd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic [1:0] in_op,
	input  dp_stat_t stat,
	input  logic res_free,
	output logic in_rdy,
	output logic res_set,
	output dp_cmd_t cmd
);
	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_DISP  = 8'b00000010,
		S_VSCAN = 8'b00000100,
		S_VDRN  = 8'b00001000,
		S_RMAP  = 8'b00010000,
		S_TSCAN = 8'b00100000,
		S_TDRN  = 8'b01000000,
		S_DONE  = 8'b10000000
	} state_t;

	state_t st_q, st_d;
	logic [1:0] cnt_q, cnt_d;
	logic [1:0] op_q;
	logic [1:0] tcase_q, tcase_d;
	logic vfull_q, vfull_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			op_q <= OpVertex;
			tcase_q <= StOk;
			vfull_q <= 1'b0;
		end else begin
			st_q <= st_d;
			cnt_q <= cnt_d;
			tcase_q <= tcase_d;
			vfull_q <= vfull_d;
			if (in_fire) op_q <= in_op;
		end
	end

	assign in_rdy = st_q == S_IDLE;

	always_comb begin
		st_d = st_q;
		cnt_d = cnt_q;
		tcase_d = tcase_q;
		vfull_d = vfull_q;
		cmd = '0;
		cmd.tcase = tcase_q;
		cmd.vfull_res = vfull_q;
		cmd.rmap_sel = cnt_q;
		res_set = 1'b0;
		unique case (st_q)
			S_IDLE: begin
				cmd.load = in_fire;
				if (in_fire && in_op != OpReserved) st_d = S_DISP;
			end
			S_DISP: begin
				cnt_d = '0;
				vfull_d = 1'b0;
				tcase_d = StOk;
				if (op_q == OpClear) begin
					cmd.clear = 1'b1;
					st_d = S_DONE;
				end else if (op_q == OpVertex) begin
					cmd.vscan_start = 1'b1;
					if (stat.vert_full) begin
						vfull_d = 1'b1;
						st_d = S_DONE;
					end else st_d = stat.weld_en ? S_VSCAN : S_VDRN;
				end else begin
					cmd.tscan_start = 1'b1;
					if (stat.bad_corner) begin
						tcase_d = StBadIndex;
						st_d = S_DONE;
					end else if (!stat.weld_en) begin
						tcase_d = StVertFull;
						st_d = S_DONE;
					end else st_d = S_RMAP;
				end
			end
			S_VSCAN: begin
				if (stat.vscan_done) st_d = S_VDRN;
				else cmd.vscan_step = 1'b1;
			end
			S_VDRN: begin
				if (stat.pipe_idle) begin
					cmd.vcommit = 1'b1;
					st_d = S_DONE;
				end
			end
			S_RMAP: begin
				cmd.rmap_rd = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == 2'd2) st_d = S_TSCAN;
			end
			S_TSCAN: begin
				if (stat.pipe_idle && stat.tscan_done) st_d = S_TDRN;
				else if (!stat.tscan_done && stat.pipe_idle) cmd.tscan_step = 1'b1;
				else if (!stat.pipe_idle && !stat.tscan_done && cnt_q == 2'd3)
					cmd.tscan_step = 1'b1;
				if (stat.pipe_idle) cnt_d = 2'd3;
			end
			S_TDRN: begin
				cmd.tcommit = 1'b1;
				st_d = S_DONE;
			end
			S_DONE: begin
				if (res_free) begin
					cmd.res_load = 1'b1;
					res_set = 1'b1;
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_fire && st_q != S_IDLE)) else $error("accept while busy");
	a_tcommit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.tcommit && !stat.pipe_idle)) else $error("triangle commit before drain");
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(st_q)) else $error("state not one-hot");
endmodule

>>> rtl/core/mesh_vertex_weld_dedup_core.sv
// top level of the mesh vertex weld and triangle dedup core
`timescale 1ns / 1ps
// Takes one item at a time. A vertex with welding on is paced by the single-port scan
// over the unique vertex store through a five-stage compare pipeline; a triangle is
// paced by a scan of the triangle store, one store read and compare per entry, ending
// early on a duplicate; clear, pass-through and refused items skip the scans. The result
// sits in an output register, so the next item is taken while it waits. Stores need no
// clearing pass after reset.
module mesh_vertex_weld_dedup_core import mvwd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
	input  logic [111:0] s_tdata,
	// opcode
	input  logic [1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// reduced_index, is_new, out_a, out_b, out_c, status
	output logic [55:0] m_tdata,
	// item_kind
	output logic [1:0] m_tuser,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_index,
	input  logic [DistW-1:0] cfg_data
);
	item_t item;
	result_t res;
	dp_cmd_t cmd;
	dp_stat_t stat;
	logic res_set, in_fire, m_valid_q;

	assign item.opcode = s_tuser;
	assign item.pos_x = s_tdata[23:0];
	assign item.pos_y = s_tdata[47:24];
	assign item.pos_z = s_tdata[71:48];
	assign item.corner_a = s_tdata[83:72];
	assign item.corner_b = s_tdata[95:84];
	assign item.corner_c = s_tdata[107:96];
	assign in_fire = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_valid_q <= 1'b0;
		else if (res_set) m_valid_q <= 1'b1;
		else if (m_tready) m_valid_q <= 1'b0;
	end
	assign m_tvalid = m_valid_q;
	assign m_tdata = {5'b00000, res.status, res.out_c, res.out_b, res.out_a, res.is_new,
		res.reduced_index};
	assign m_tuser = res.item_kind;

	mvwd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_op(item.opcode),
		.stat(stat), .res_free(!m_valid_q || m_tready), .in_rdy(s_tready),
		.res_set(res_set), .cmd(cmd)
	);

	mvwd_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(item), .cfg_we(cfg_valid),
		.cfg_idx(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .stat(stat), .res(res)
	);
endmodule
